>>> design/servo_command_packet_framer_assert.svh
// Assertion macros used by the servo command packet framer top level.
`ifndef SERVO_COMMAND_PACKET_FRAMER_ASSERT_SVH
`define SERVO_COMMAND_PACKET_FRAMER_ASSERT_SVH

// Checks a property on every rising clock edge outside reset.
`define SCPF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SCPF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/scpf_pkg.sv
// Package with the types and constants of the servo command packet framer.
package scpf_pkg;

  localparam int NUM_CELLS   = 8;
  localparam int NUM_SLICES  = 5;
  localparam int SLICE_W     = 7;
  localparam int EXT_W       = NUM_SLICES * SLICE_W;
  localparam int BYTE_W      = 8;
  localparam int ADDR_W      = 7;
  localparam int OPCODE_W    = 5;
  localparam int VALUE_W     = 32;
  localparam int GROUPS_W    = 3;

  localparam logic [BYTE_W-1:0] MARK_BIT = 8'h80;

  typedef struct packed {
    logic [OPCODE_W-1:0]       drive_opcode;
    logic signed [VALUE_W-1:0] value;
  } scpf_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last_byte;
  } scpf_out_t;

  // Contents of one chain cell: occupied flag, checksum flag and the byte.
  typedef struct packed {
    logic              occ;
    logic              last;
    logic [BYTE_W-1:0] data;
  } scpf_cell_t;

  typedef struct packed {
    logic load;
    logic shift;
  } scpf_cell_ctl_t;

endpackage

>>> design/scpf_cell.sv
// One cell of the byte chain: holds a packet byte and takes its neighbour's on a shift.
module scpf_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  scpf_pkg::scpf_cell_ctl_t ctl,
  input  scpf_pkg::scpf_cell_t  load_val,
  input  scpf_pkg::scpf_cell_t  nbr_val,
  output scpf_pkg::scpf_cell_t  q
);
  import scpf_pkg::*;

  logic              occ_r;
  logic              last_r;
  logic [BYTE_W-1:0] data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else if (ctl.load) begin
      occ_r <= load_val.occ;
    end else if (ctl.shift) begin
      occ_r <= nbr_val.occ;
    end
  end

  // The payload needs no reset; the occupied flag qualifies it.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      last_r <= load_val.last;
      data_r <= load_val.data;
    end else if (ctl.shift) begin
      last_r <= nbr_val.last;
      data_r <= nbr_val.data;
    end
  end

  assign q = '{occ: occ_r, last: last_r, data: data_r};

endmodule

>>> design/scpf_loader.sv
// Lays out a command packet across the chain cells, with the checksum slot left open.
module scpf_loader (
  input  scpf_pkg::scpf_in_t                      in_data,
  input  logic [scpf_pkg::ADDR_W-1:0]             device_address,
  output scpf_pkg::scpf_cell_t [scpf_pkg::NUM_CELLS-1:0] load_cells
);
  import scpf_pkg::*;

  logic [EXT_W-1:0]    ext;
  logic [SLICE_W-1:0]  slices [NUM_SLICES];
  logic [GROUPS_W-1:0] n;
  logic                sgn;

  assign sgn = in_data.value[VALUE_W-1];
  assign ext = {{(EXT_W-VALUE_W){sgn}}, in_data.value};

  always_comb begin
    for (int s = 0; s < NUM_SLICES; s++) begin
      slices[s] = ext[s*SLICE_W +: SLICE_W];
    end
  end

  // Fewest extra groups: the value fits when the top bit of the top kept slice
  // and all bits above it are copies of the sign bit.
  always_comb begin
    priority if (in_data.value[31:27] != {5{sgn}}) begin
      n = 3'd4;
    end else if (in_data.value[31:20] != {12{sgn}}) begin
      n = 3'd3;
    end else if (in_data.value[31:13] != {19{sgn}}) begin
      n = 3'd2;
    end else if (in_data.value[31:6] != {26{sgn}}) begin
      n = 3'd1;
    end else begin
      n = 3'd0;
    end
  end

  always_comb begin
    load_cells = '0;
    load_cells[0] = '{occ: 1'b1, last: 1'b0, data: {1'b0, device_address}};
    // With five groups the length field carries out of the byte and is lost.
    load_cells[1] = '{occ: 1'b1, last: 1'b0,
                      data: BYTE_W'(MARK_BIT + {n, 5'b0} + {3'b0, in_data.drive_opcode})};
    for (int k = 2; k < NUM_CELLS; k++) begin
      if (GROUPS_W'(k-2) <= n) begin
        load_cells[k] = '{occ: 1'b1, last: 1'b0,
                          data: {1'b1, slices[GROUPS_W'(n - GROUPS_W'(k-2))]}};
      end else if (4'(k-2) == ({1'b0, n} + 4'd1)) begin
        load_cells[k] = '{occ: 1'b1, last: 1'b1, data: MARK_BIT};
      end
    end
  end

endmodule

>>> design/servo_command_packet_framer.sv
// Top level of the servo command packet framer: byte chain, checksum and configuration.
//
//   channel | direction | payload                      | handshake
//   in_     | input     | drive_opcode, value          | in_valid / in_ready
//   out_    | output    | out_byte, last_byte          | out_valid / out_ready
//   cfg_    | input     | device_address (7 bits)      | cfg_valid / cfg_ready
//
// A command of n extra groups becomes n+4 bytes (4 to 8), sent one per cycle
// from the head of an eight-cell chain while out_ready is high.
// The next command is taken in the same cycle as the checksum byte leaves.
// Reset (rst_n low, synchronous) empties the chain and clears the address.
// A stalled output simply freezes the chain; nothing is lost.
module servo_command_packet_framer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  scpf_pkg::scpf_in_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output scpf_pkg::scpf_out_t          out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [scpf_pkg::ADDR_W-1:0]  cfg_data
);
  import scpf_pkg::*;

  `include "servo_command_packet_framer_assert.svh"

  logic [ADDR_W-1:0]             device_address_r;
  logic [SLICE_W-1:0]            sum_r;
  logic [SLICE_W-1:0]            sum_nxt;
  scpf_cell_t [NUM_CELLS-1:0]    load_cells;
  scpf_cell_t [NUM_CELLS-1:0]    cells;
  scpf_cell_ctl_t                ctl;
  logic [NUM_CELLS-1:0]          occ_vec;
  logic [NUM_CELLS-1:0]          last_vec;
  logic                          head_last;
  logic                          in_xfer;
  logic                          out_xfer;

  // The configuration register can always take a write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_address_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      device_address_r <= cfg_data;
    end
  end

  scpf_loader u_loader (
    .in_data        (in_data),
    .device_address (device_address_r),
    .load_cells     (load_cells)
  );

  // The chain drains towards cell 0, so an empty head means an empty chain.
  // A new command may also enter while the checksum byte is being taken.
  assign head_last = cells[0].last;
  assign out_valid = cells[0].occ;
  assign out_xfer  = out_valid && out_ready;
  assign in_ready  = !cells[0].occ || (head_last && out_ready);
  assign in_xfer   = in_valid && in_ready;

  assign ctl = '{load: in_xfer, shift: out_xfer};

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_chain
    scpf_cell_t nbr;
    if (k == NUM_CELLS-1) begin : g_tail
      assign nbr = '0;
    end else begin : g_body
      assign nbr = cells[k+1];
    end
    scpf_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .load_val (load_cells[k]),
      .nbr_val  (nbr),
      .q        (cells[k])
    );
    assign occ_vec[k]  = cells[k].occ;
    assign last_vec[k] = cells[k].last;
  end

  // The running sum gathers the low seven bits of every byte as it leaves the
  // head. When the checksum slot reaches the head, its byte is the mark bit
  // over that sum, which is the packet total modulo 128.
  always_comb begin
    sum_nxt = sum_r;
    if (in_xfer) begin
      sum_nxt = '0;
    end else if (out_xfer && !head_last) begin
      sum_nxt = SLICE_W'(sum_r + cells[0].data[SLICE_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else begin
      sum_r <= sum_nxt;
    end
  end

  assign out_data.out_byte  = head_last ? {1'b1, sum_r} : cells[0].data;
  assign out_data.last_byte = head_last;

  // Occupied cells always form an unbroken run starting at the head.
  `SCPF_ASSERT(a_chain_packed, ((occ_vec + NUM_CELLS'(1)) & occ_vec) == '0,
    "chain has a gap between occupied cells")

  // A non-empty chain holds exactly one checksum slot.
  `SCPF_ASSERT(a_one_checksum,
    $countones(occ_vec & last_vec) == (occ_vec[0] ? 1 : 0),
    "chain does not hold exactly one checksum slot")

  // Every accepted command starts with its address byte at the head.
  `SCPF_ASSERT_NEXT(a_load_head, in_xfer,
    out_valid && !head_last && (cells[0].data == {1'b0, $past(device_address_r)}),
    "address byte missing after command transaction")

  // Each data byte taken adds its low bits into the running sum.
  `SCPF_ASSERT_NEXT(a_sum_update, out_xfer && !head_last,
    sum_r == SLICE_W'($past(sum_r) + $past(cells[0].data[SLICE_W-1:0])),
    "running sum not updated after byte transaction")

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the servo command packet framer.
module testbench;
  import scpf_pkg::*;

  // The clock period is 12 ns. The watchdog gives up after this many cycles
  // in which no transaction completes on any of the three channels.
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 20;

  // These are the inclusive bounds of each packet length. A value outside
  // the bounds of a class needs at least one more seven-bit group.
  localparam int GROUP4_HI = 32'sh07FF_FFFF;
  localparam int GROUP4_LO = -32'sh0800_0000;
  localparam int GROUP3_HI = 32'sh000F_FFFF;
  localparam int GROUP3_LO = -32'sh0010_0000;
  localparam int GROUP2_HI = 32'sh0000_1FFF;
  localparam int GROUP2_LO = -32'sh0000_2000;
  localparam int GROUP1_HI = 32'sh0000_003F;
  localparam int GROUP1_LO = -32'sh0000_0040;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  scpf_in_t          in_data;
  logic              out_valid;
  logic              out_ready = 1'b0;
  scpf_out_t         out_data;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [ADDR_W-1:0] cfg_data;

  // This mirrors the address register of the block. It is updated when a
  // configuration transaction completes.
  logic [ADDR_W-1:0] device_addr;

  // These are the packet bytes that are still due, oldest first.
  scpf_out_t packet_bytes_due[$];

  int mismatch_count = 0;
  int quiet_cycles = 0;
  int sender_idle_pct;
  int receiver_stall_pct;

  servo_command_packet_framer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // This builds the whole packet for one command and queues its bytes. The
  // byte order is the address, then the length and opcode byte, then the
  // data groups with the most significant first, then the checksum. The
  // length field of a five-group packet overflows bit 7 and is lost, so
  // that byte carries the opcode alone. The top group of a five-group
  // packet takes copies of the sign bit from above bit 31.
  function automatic void frame_command(input logic [ADDR_W-1:0] addr, input scpf_in_t cmd);
    int                   v;
    logic [GROUPS_W-1:0]  extra;
    logic [EXT_W-1:0]     ext;
    logic [SLICE_W-1:0]   sum;
    logic [BYTE_W-1:0]    b;
    v = cmd.value;
    if (v > GROUP4_HI || v < GROUP4_LO) begin
      extra = 3'd4;
    end else if (v > GROUP3_HI || v < GROUP3_LO) begin
      extra = 3'd3;
    end else if (v > GROUP2_HI || v < GROUP2_LO) begin
      extra = 3'd2;
    end else if (v > GROUP1_HI || v < GROUP1_LO) begin
      extra = 3'd1;
    end else begin
      extra = 3'd0;
    end
    ext = {{(EXT_W - VALUE_W){cmd.value[VALUE_W-1]}}, cmd.value};

    b = {1'b0, addr};
    packet_bytes_due.push_back({b, 1'b0});
    sum = b[SLICE_W-1:0];

    b = MARK_BIT + {extra, 5'b0} + {3'b0, cmd.drive_opcode};
    packet_bytes_due.push_back({b, 1'b0});
    sum = sum + b[SLICE_W-1:0];

    for (int i = int'(extra); i >= 0; i--) begin
      b = MARK_BIT | {1'b0, ext[SLICE_W*i +: SLICE_W]};
      packet_bytes_due.push_back({b, 1'b0});
      sum = sum + b[SLICE_W-1:0];
    end

    packet_bytes_due.push_back({1'b1, sum, 1'b1});
  endfunction

  // This picks a packet length class at random and then a value that fits
  // it, so that every length turns up often. One command in six carries a
  // fully random value instead.
  function automatic scpf_in_t random_command();
    scpf_in_t cmd;
    int       width;
    int       shift;
    int       raw;
    cmd.drive_opcode = OPCODE_W'($urandom_range(31));
    raw = $urandom;
    if ($urandom_range(5) == 0) begin
      cmd.value = raw;
    end else begin
      width = SLICE_W * ($urandom_range(4) + 1);
      if (width > VALUE_W) begin
        width = VALUE_W;
      end
      shift = VALUE_W - width;
      cmd.value = (raw <<< shift) >>> shift;
    end
    return cmd;
  endfunction

  // This offers one command on the input channel and waits for the
  // transaction to complete. Valid stays high after that, so a following
  // call at the next falling edge either presents a new command or lowers
  // valid for an idle gap. It is never lowered and raised in one step.
  task automatic send_command(input scpf_in_t cmd);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = cmd;
    do @(posedge clk); while (!in_ready);
    frame_command(device_addr, cmd);
  endtask

  // This withdraws the input channel and holds it off until every byte
  // that is due has left the block.
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (packet_bytes_due.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // This writes the address register. It is only called once the block has
  // drained, as the last checksum byte leaves the block idle.
  task automatic write_device_address(input logic [ADDR_W-1:0] addr);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = addr;
    do @(posedge clk); while (!cfg_ready);
    device_addr = addr;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // This test sends the values at both edges of every packet length, from
  // one group up to five, together with the largest and smallest values.
  // The address is still at its reset value, and the opcodes run through
  // both extremes.
  task automatic test_group_boundaries();
    int       edge_values[20];
    scpf_in_t cmd;
    edge_values = '{32'sh0000_0000, 32'shFFFF_FFFF, 32'sh0000_003F, 32'sh0000_0040,
                    32'shFFFF_FFC0, 32'shFFFF_FFBF, 32'sh0000_1FFF, 32'sh0000_2000,
                    32'shFFFF_E000, 32'shFFFF_DFFF, 32'sh000F_FFFF, 32'sh0010_0000,
                    32'shFFF0_0000, 32'shFFEF_FFFF, 32'sh07FF_FFFF, 32'sh0800_0000,
                    32'shF800_0000, 32'shF7FF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000};
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    for (int i = 0; i < 20; i++) begin
      cmd.drive_opcode = OPCODE_W'((i % 2 == 0) ? i : 32 - i);
      cmd.value        = edge_values[i];
      send_command(cmd);
    end
    wait_drained();
  endtask

  // This test drives the address register to its top value, framing two
  // five-group commands, and then back to zero, framing a one-group command.
  task automatic test_address_extremes();
    scpf_in_t cmd;
    write_device_address(7'h7F);
    cmd.drive_opcode = 5'h1F;
    cmd.value        = 32'sh8000_0000;
    send_command(cmd);
    cmd.drive_opcode = 5'h00;
    cmd.value        = 32'sh7FFF_FFFF;
    send_command(cmd);
    wait_drained();
    write_device_address(7'h00);
    cmd.drive_opcode = 5'h15;
    cmd.value        = 32'shFFFF_FFFF;
    send_command(cmd);
    wait_drained();
  endtask

  // This test sends random commands under a given amount of idling on each
  // side, with a fresh address for the phase. Halfway through, the sender
  // holds back until the block has emptied completely.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    wait_drained();
    write_device_address(ADDR_W'($urandom_range(127)));
    for (int k = 0; k < count; k++) begin
      if (k == count / 2) begin
        wait_drained();
      end
      send_command(random_command());
    end
    wait_drained();
  endtask

  // The receiver stalls at random. Its ready changes only at falling edges.
  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= receiver_stall_pct);
  end

  // Each result transaction is checked against the oldest byte that is due.
  always @(posedge clk) begin
    scpf_out_t due;
    if (rst_n && out_valid && out_ready) begin
      if (packet_bytes_due.size() == 0) begin
        $error("unexpected packet byte 0x%02h (last_byte %0b)",
               out_data.out_byte, out_data.last_byte);
        mismatch_count++;
      end else begin
        due = packet_bytes_due.pop_front();
        if (out_data.out_byte !== due.out_byte) begin
          $error("out_byte: expected 0x%02h, got 0x%02h", due.out_byte, out_data.out_byte);
          mismatch_count++;
        end
        if (out_data.last_byte !== due.last_byte) begin
          $error("last_byte: expected %0b, got %0b", due.last_byte, out_data.last_byte);
          mismatch_count++;
        end
      end
    end
  end

  // The watchdog ends a run that has stopped making progress on all three
  // channels.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_data            = '0;
    cfg_valid          = 1'b0;
    cfg_data           = '0;
    device_addr        = '0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_group_boundaries();
    test_address_extremes();
    test_random_traffic(0, 0, 37);
    test_random_traffic(68, 0, 37);
    test_random_traffic(0, 68, 37);
    test_random_traffic(31, 31, 37);

    // Any stray byte that turns up while the block settles is caught by the
    // result checker.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && packet_bytes_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
